FILE: src/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared definitions for the binary mask square dilation block
// Field widths, register map, reset values, sequencer states and the
// configuration bundle handed from the register file to the core.
// ----------------------------------------------------------------------------
package mbd_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_RADIUS = 7;

	localparam int CFG_DIM_W = 11;
	localparam int CFG_RAD_W = 3;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 10;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_DILATE_RADIUS = 2'd2;

	localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH   = 11'd1024;
	localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT  = 11'd1024;
	localparam logic [CFG_RAD_W-1:0] RST_DILATE_RADIUS = 3'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_CHECK,
		ST_READ,
		ST_TAIL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CFG_DIM_W-1:0] frame_width;
		logic [CFG_DIM_W-1:0] frame_height;
		logic [CFG_RAD_W-1:0] dilate_radius;
		logic                 restart;
	} cfg_t;

endpackage

FILE: src/mbd_cfg.sv
// ----------------------------------------------------------------------------
// mbd_cfg: configuration register file
// APB-style write and read of frame width, frame height and radius; a write
// to a known register raises a restart strobe for the core.
// ----------------------------------------------------------------------------
module mbd_cfg
	import mbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [CFG_DIM_W-1:0] frame_width_q;
	logic [CFG_DIM_W-1:0] frame_height_q;
	logic [CFG_RAD_W-1:0] dilate_radius_q;
	logic [1:0]           reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= RST_FRAME_WIDTH;
			frame_height_q  <= RST_FRAME_HEIGHT;
			dilate_radius_q <= RST_DILATE_RADIUS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_WIDTH:   frame_width_q   <= pwdata[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= pwdata[CFG_DIM_W-1:0];
				REG_DILATE_RADIUS: dilate_radius_q <= pwdata[CFG_RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_WIDTH:   prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(frame_height_q);
			REG_DILATE_RADIUS: prdata = APB_DATA_W'(dilate_radius_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.frame_width   = frame_width_q;
	assign cfg.frame_height  = frame_height_q;
	assign cfg.dilate_radius = dilate_radius_q;
	assign cfg.restart       = wr_en && (reg_idx == REG_FRAME_WIDTH ||
		reg_idx == REG_FRAME_HEIGHT || reg_idx == REG_DILATE_RADIUS);

endmodule

FILE: src/mbd_ram.sv
// ----------------------------------------------------------------------------
// mbd_ram: single-port bit memory for the horizontal run store
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module mbd_ram #(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic mem [2**AW];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/mbd_core.sv
// ----------------------------------------------------------------------------
// mbd_core: sequencer and datapath of the dilation
// A shift window forms the horizontal OR of each input row into the run
// store; each output ORs the stored runs of its window rows, one read a cycle.
// ----------------------------------------------------------------------------
module mbd_core
	import mbd_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic             mask_bit,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             dilated_bit,
	output logic [COL_W-1:0] pixel_col,
	output logic [ROW_W-1:0] pixel_row,
	output logic             frame_last
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int WH    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int HROWS = 2 * MAX_RADIUS + 2;
	localparam int RB    = $clog2(HROWS);
	localparam int VW    = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
	localparam int RWW   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
	localparam int SRW   = 2 * MAX_RADIUS + 1;
	localparam int AW    = RB + CW;

	state_t state_q, state_d;

	logic [WW-1:0]  w_eff;
	logic [WH-1:0]  h_eff;
	logic [RW-1:0]  r_eff;
	logic [CW-1:0]  w_last;
	logic [WH-1:0]  h_last;
	logic [SRW-1:0] win_mask;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [WH-1:0] in_row_q, out_row_q;
	logic [RB-1:0] in_ring_q, out_ring_q, wring_q, rd_ring_q;
	logic [WH-1:0] rd_row_q, rd_end_q;
	logic          rd_pend_q;
	logic [VW-1:0] vcol_q;
	logic [SRW-1:0] sr_q;
	logic          acc_q;

	logic             out_valid_q, dilated_q, last_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic           push_ok, col_is_last, push_wr, h_push;
	logic [SRW-1:0] sr_push, sr_fl;
	logic [AW-1:0]  push_addr, fl_addr;
	logic [VW-1:0]  vcol_n;
	logic           fl_wr, fl_done, h_fl;
	logic [VW-1:0]  nc;
	logic [RWW-1:0] nr;
	logic           out_rdy;
	logic [WH-1:0]  rd_start;
	logic [RW-1:0]  rd_back;
	logic [RB:0]    ring_tmp;
	logic [RB-1:0]  ring_start;
	logic           load, emit_last, rd_done;

	logic          ram_we, ram_wdata, ram_rdata;
	logic [AW-1:0] ram_addr;

	// effective frame and window size
	always_comb begin
		if (cfg.frame_width == '0) begin
			w_eff = WW'(1);
		end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h_eff = WH'(1);
		end else if (int'(cfg.frame_height) > MAX_HEIGHT) begin
			h_eff = WH'(MAX_HEIGHT);
		end else begin
			h_eff = WH'(cfg.frame_height);
		end
		if (int'(cfg.dilate_radius) > MAX_RADIUS) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(cfg.dilate_radius);
		end
	end

	assign w_last = CW'(w_eff - WW'(1));
	assign h_last = h_eff - WH'(1);

	always_comb begin
		for (int i = 0; i < SRW; i++) begin
			win_mask[i] = (i <= 2 * int'(r_eff));
		end
	end

	// push path: shift window and run write
	assign push_ok     = !action && (in_row_q < h_eff);
	assign col_is_last = (in_col_q == w_last);
	assign sr_push     = (((in_col_q == '0) ? '0 : sr_q) << 1) | SRW'(mask_bit);
	assign h_push      = |(sr_push & win_mask);
	assign push_wr     = (VW'(in_col_q) >= VW'(r_eff));
	assign push_addr   = {in_ring_q, CW'(VW'(in_col_q) - VW'(r_eff))};

	// row end: shift zeros to finish the right-hand runs
	assign sr_fl   = sr_q << 1;
	assign vcol_n  = vcol_q + VW'(1);
	assign h_fl    = |(sr_fl & win_mask);
	assign fl_wr   = (vcol_n >= VW'(r_eff));
	assign fl_addr = {wring_q, CW'(vcol_n - VW'(r_eff))};
	assign fl_done = (vcol_n == VW'(w_last) + VW'(r_eff));

	// output readiness and first window row
	always_comb begin
		nc = VW'(out_col_q) + VW'(r_eff);
		if (nc > VW'(w_last)) begin
			nc = VW'(w_last);
		end
		nr = RWW'(out_row_q) + RWW'(r_eff);
		if (nr > RWW'(h_last)) begin
			nr = RWW'(h_last);
		end
		out_rdy = (out_row_q < h_eff) && ((nr < RWW'(in_row_q)) ||
			((nr == RWW'(in_row_q)) && (nc < VW'(in_col_q))));
		if (RWW'(out_row_q) >= RWW'(r_eff)) begin
			rd_start = WH'(RWW'(out_row_q) - RWW'(r_eff));
			rd_back  = r_eff;
		end else begin
			rd_start = '0;
			rd_back  = RW'(out_row_q);
		end
		if (out_ring_q >= RB'(rd_back)) begin
			ring_tmp = (RB+1)'(out_ring_q) - (RB+1)'(rd_back);
		end else begin
			ring_tmp = (RB+1)'(out_ring_q) + (RB+1)'(HROWS) - (RB+1)'(rd_back);
		end
		ring_start = RB'(ring_tmp);
	end

	assign rd_done   = (rd_row_q == rd_end_q);
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit_last = (out_row_q == h_last) && (out_col_q == w_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = {rd_ring_q, out_col_q};
		ram_wdata = h_push;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (push_ok) begin
						ram_we    = push_wr;
						ram_addr  = push_addr;
						ram_wdata = h_push;
						state_d   = (col_is_last && r_eff != '0) ? ST_FLUSH : ST_CHECK;
					end else begin
						state_d = action ? ST_CHECK : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				ram_we    = fl_wr;
				ram_addr  = fl_addr;
				ram_wdata = h_fl;
				if (fl_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = out_rdy ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				if (rd_done) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
			rd_row_q   <= '0;
			rd_end_q   <= '0;
			rd_ring_q  <= '0;
			rd_pend_q  <= 1'b0;
		end else if (cfg.restart) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
		end else begin
			if (state_q == ST_IDLE && in_valid && push_ok) begin
				if (col_is_last) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + WH'(1);
					in_ring_q <= (in_ring_q == RB'(HROWS - 1)) ? '0 : in_ring_q + RB'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (state_q == ST_CHECK) begin
				rd_row_q  <= rd_start;
				rd_end_q  <= WH'(nr);
				rd_ring_q <= ring_start;
				rd_pend_q <= 1'b0;
			end
			if (state_q == ST_READ) begin
				rd_row_q  <= rd_row_q + WH'(1);
				rd_ring_q <= (rd_ring_q == RB'(HROWS - 1)) ? '0 : rd_ring_q + RB'(1);
				rd_pend_q <= 1'b1;
			end
			if (load) begin
				if (emit_last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_ring_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_ring_q <= '0;
				end else if (out_col_q == w_last) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + WH'(1);
					out_ring_q <= (out_ring_q == RB'(HROWS - 1)) ? '0 : out_ring_q + RB'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// window and accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && push_ok) begin
			sr_q    <= sr_push;
			vcol_q  <= VW'(in_col_q);
			wring_q <= in_ring_q;
		end
		if (state_q == ST_FLUSH) begin
			sr_q   <= sr_fl;
			vcol_q <= vcol_n;
		end
		if (state_q == ST_CHECK) begin
			acc_q <= 1'b0;
		end
		if (state_q == ST_READ) begin
			acc_q <= acc_q | (rd_pend_q & ram_rdata);
		end
		if (state_q == ST_TAIL) begin
			acc_q <= acc_q | ram_rdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dilated_q <= acc_q;
			col_q     <= COL_W'(out_col_q);
			row_q     <= ROW_W'(out_row_q);
			last_q    <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign dilated_bit = dilated_q;
	assign pixel_col   = col_q;
	assign pixel_row   = row_q;
	assign frame_last  = last_q;

	mbd_ram #(
		.AW(AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_TAIL || state_q == ST_CHECK) |-> !ram_we)
		else $error("run store written during window read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rd_row_q <= rd_end_q))
		else $error("window row past last row");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= in_row_q)
		else $error("output row ahead of input row");

	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result beat not presented");
`endif

endmodule

FILE: src/binary_mask_square_dilation.sv
// Sequence: a beat is taken in ST_IDLE; a pixel past the frame end stays there, others pass
// ST_FLUSH at a row end when r > 0, then ST_CHECK. One that releases a result reads each
// window row's run from the single-port run store in ST_READ, folds the last in ST_TAIL and
// leaves via the output register in ST_EMIT. One beat per item; none is taken outside ST_IDLE.
// Reset: asynchronous, active low; counters cleared, registers to 1024, 1024, radius 1.
// The run store is not cleared; only entries written in the current frame are read.
// ----------------------------------------------------------------------------
// binary_mask_square_dilation: streamed binary dilation with a square window
// Raster-order mask pixels in, dilated pixels with their position out; drain
// beats release the outputs still pending at the end of the frame.
// ----------------------------------------------------------------------------
module binary_mask_square_dilation
	import mbd_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic                  mask_bit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  dilated_bit,
	output logic [COL_W-1:0]      pixel_col,
	output logic [ROW_W-1:0]      pixel_row,
	output logic                  frame_last
);

	cfg_t cfg;

	mbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbd_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.mask_bit    (mask_bit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dilated_bit (dilated_bit),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.frame_last  (frame_last)
	);

endmodule

FILE: test/binary_mask_square_dilation_tb.sv
// ----------------------------------------------------------------------------
// binary_mask_square_dilation_tb: self-checking bench for the square dilation
// Streams binary masks in raster order with mid-frame and end-of-frame drain
// beats. Register writes land between frames and also abort frames in flight.
// A behavioural copy of the window logic predicts every released pixel, and
// each result is compared against it in order.
// ----------------------------------------------------------------------------
module binary_mask_square_dilation_tb
	import mbd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = (2 * DEF_MAX_RADIUS + 1) * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum int {SHAPE_SMALL, SHAPE_WIDE, SHAPE_TALL} frame_shape_t;

	typedef struct {
		logic             dilated;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} dilated_pixel_t;

	class dilation_mirror;
		logic [CFG_DIM_W-1:0] width_reg;
		logic [CFG_DIM_W-1:0] height_reg;
		logic [CFG_RAD_W-1:0] radius_reg;
		int in_col, in_row, out_col, out_row;
		int errors;
		bit ring [RING_DEPTH];
		dilated_pixel_t due[$];

		function new();
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			radius_reg = RST_DILATE_RADIUS;
			errors     = 0;
			restart();
		endfunction

		function void restart();
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int eff_width();
			if (width_reg == 0) return 1;
			return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == 0) return 1;
			return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
		endfunction

		function int eff_radius();
			return (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_reg);
		endfunction

		function bit inputs_done();
			return in_row >= eff_height();
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_FRAME_WIDTH: width_reg = value[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: height_reg = value[CFG_DIM_W-1:0];
				REG_DILATE_RADIUS: radius_reg = value[CFG_RAD_W-1:0];
				default: return;
			endcase
			restart();
		endfunction

		function logic window_hit(int w, int h, int r);
			for (int y = out_row - r; y <= out_row + r; y++)
				for (int x = out_col - r; x <= out_col + r; x++)
					if (y >= 0 && y < h && x >= 0 && x < w && ring[(y * w + x) % RING_DEPTH])
						return 1'b1;
			return 1'b0;
		endfunction

		function void take_beat(logic act, logic pix);
			int w, h, r, need_c, need_r;
			dilated_pixel_t px;
			w = eff_width();
			h = eff_height();
			r = eff_radius();
			if (act == ACT_PIXEL && in_row >= h) return;
			if (act == ACT_PIXEL && in_row < h) begin
				ring[(in_row * w + in_col) % RING_DEPTH] = pix;
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
				end
			end
			if (out_row >= h) return;
			need_c = (out_col + r > w - 1) ? w - 1 : out_col + r;
			need_r = (out_row + r > h - 1) ? h - 1 : out_row + r;
			if (need_r * w + need_c >= in_row * w + in_col) return;
			px.dilated = window_hit(w, h, r);
			px.col     = out_col[COL_W-1:0];
			px.row     = out_row[ROW_W-1:0];
			px.last    = (out_row == h - 1) && (out_col == w - 1);
			due.push_back(px);
			if (px.last) begin
				restart();
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		function void compare_output(logic d, logic [COL_W-1:0] c, logic [ROW_W-1:0] rw,
			logic last);
			dilated_pixel_t want;
			if (due.size() == 0) begin
				$error("unexpected result beat: col %0d row %0d", c, rw);
				errors++;
				return;
			end
			want = due.pop_front();
			if (d !== want.dilated) begin
				$error("dilated_bit: expected %0d, actual %0d", want.dilated, d);
				errors++;
			end
			if (c !== want.col) begin
				$error("pixel_col: expected %0d, actual %0d", want.col, c);
				errors++;
			end
			if (rw !== want.row) begin
				$error("pixel_row: expected %0d, actual %0d", want.row, rw);
				errors++;
			end
			if (last !== want.last) begin
				$error("frame_last: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = 1'b0;
	logic                  mask_bit = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  dilated_bit;
	logic [COL_W-1:0]      pixel_col;
	logic [ROW_W-1:0]      pixel_row;
	logic                  frame_last;

	dilation_mirror marks = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int beats_sent = 0;
	int cycles = 0;

	binary_mask_square_dilation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.mask_bit(mask_bit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dilated_bit(dilated_bit),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.frame_last(frame_last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			marks.take_beat(action, mask_bit);
		if (out_valid && out_ready)
			marks.compare_output(dilated_bit, pixel_col, pixel_row, frame_last);
	end

	// result side back-pressure
	always begin
		@(negedge clk);
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		out_ready <= 1'b1;
	end

	task automatic send_beat(input logic act, input logic pix);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		mask_bit <= pix;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] word;
		word = ($urandom() & 32'hFFFF_F800) | value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		marks.set_reg(idx, word);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (marks.due.size() != 0) @(negedge clk);
		repeat (48) @(negedge clk);
	endtask

	initial begin
		int n, npush, frame_no, density;
		bit aborted, configure;
		frame_shape_t shape;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry, early drain with nothing ready
		send_beat(ACT_PIXEL, 1'b1);
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_PIXEL, 1'b1);
		send_beat(ACT_DRAIN, 1'b0);
		wait_idle();

		// zero sizes fold to a single pixel frame
		write_reg(REG_FRAME_WIDTH, 32'd0);
		write_reg(REG_FRAME_HEIGHT, 32'd0);
		write_reg(REG_DILATE_RADIUS, 32'd0);
		send_beat(ACT_PIXEL, 1'b1);
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_DRAIN, 1'b1);
		wait_idle();

		// oversize width saturates, widest window, frame then aborted
		write_reg(REG_FRAME_WIDTH, 32'd2047);
		write_reg(REG_FRAME_HEIGHT, 32'd1);
		write_reg(REG_DILATE_RADIUS, 32'd7);
		for (int i = 0; i < 10; i++)
			send_beat(ACT_PIXEL, i == 9);
		wait_idle();

		// small frame: spare register write mid-frame, pixel past the end, drains
		write_reg(REG_FRAME_WIDTH, 32'd3);
		write_reg(REG_FRAME_HEIGHT, 32'd2);
		write_reg(REG_DILATE_RADIUS, 32'd2);
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_PIXEL, 1'b1);
		wait_idle();
		write_reg(REG_SPARE, $urandom());
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_PIXEL, 1'b0);
		send_beat(ACT_PIXEL, 1'b1);
		while (marks.inputs_done())
			send_beat(ACT_DRAIN, 1'b0);
		send_beat(ACT_DRAIN, 1'b1);

		frame_no = 0;
		aborted  = 1'b1;
		while (beats_sent < 1350) begin
			if (beats_sent >= 1150) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 25);
				stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 25);
			end
			if (frame_no % 20 == 1)
				shape = SHAPE_WIDE;
			else if (frame_no % 20 == 4)
				shape = SHAPE_TALL;
			else
				shape = SHAPE_SMALL;
			configure = aborted || shape != SHAPE_SMALL || $urandom_range(0, 2) != 0;
			if (configure) begin
				wait_idle();
				case (shape)
					SHAPE_WIDE: begin
						write_reg(REG_FRAME_WIDTH, $urandom_range(1024, 2047));
						write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 3));
					end
					SHAPE_TALL: begin
						write_reg(REG_FRAME_WIDTH, $urandom_range(0, 1));
						write_reg(REG_FRAME_HEIGHT, $urandom_range(1024, 2047));
					end
					default: begin
						write_reg(REG_FRAME_WIDTH, $urandom_range(0, 12));
						write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8));
					end
				endcase
				write_reg(REG_DILATE_RADIUS, $urandom_range(0, 7));
			end
			case ($urandom_range(0, 2))
				0: density = 3;
				1: density = 25;
				default: density = 60;
			endcase
			n = marks.eff_width() * marks.eff_height();
			if (shape != SHAPE_SMALL)
				npush = $urandom_range(530, 580);
			else if ($urandom_range(0, 19) == 0)
				npush = $urandom_range(0, n - 1);
			else
				npush = n;
			aborted = npush < n;
			for (int i = 0; i < npush; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_beat(ACT_DRAIN, $urandom_range(0, 1));
				send_beat(ACT_PIXEL, $urandom_range(0, 99) < density);
			end
			if (!aborted) begin
				while (marks.inputs_done())
					send_beat(($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_DRAIN,
						$urandom_range(0, 1));
				if ($urandom_range(0, 4) == 0)
					send_beat(ACT_DRAIN, $urandom_range(0, 1));
			end
			frame_no++;
		end

		in_valid <= 1'b0;
		while (marks.due.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
		if (marks.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/mbd_pkg.sv
src/mbd_cfg.sv
src/mbd_ram.sv
src/mbd_core.sv
src/binary_mask_square_dilation.sv
test/binary_mask_square_dilation_tb.sv
